>>> rtl/bfdm_pkg.sv
// Package for the block frame-difference motion detector.
// Holds sizes, register indexes and the pixel info struct shared by all modules but bfdm_ram.
// No dependencies.
package bfdm_pkg;

    localparam int MAX_WIDTH   = 320;
    localparam int MAX_HEIGHT  = 240;
    localparam int MAX_TILE    = 32;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int PIX_W   = 16;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int TCOL_W  = $clog2(MAX_WIDTH);
    localparam int SUM_W   = 17;
    localparam int CNT_W   = 17;
    localparam int DIFF_W  = 7;

    localparam int FW_W    = 9;
    localparam int FH_W    = 8;
    localparam int TS_W    = 6;
    localparam int TT_W    = 7;
    localparam int MT_W    = 17;
    localparam int CIT_W   = $clog2(MAX_TILE);
    localparam int TSQ_W   = 11;
    localparam int LIMIT_W = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 3'd4;

    localparam logic [FW_W-1:0] FW_RESET = 9'd320;
    localparam logic [FH_W-1:0] FH_RESET = 8'd240;
    localparam logic [TS_W-1:0] TS_RESET = 6'd8;
    localparam logic [TT_W-1:0] TT_RESET = 7'd10;
    localparam logic [MT_W-1:0] MT_RESET = 17'd5;

    // one accepted pixel on its way from the position logic to the accumulator
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [TCOL_W-1:0] tcol;
        logic              first_tile;
        logic              tile_done;
        logic              frame_end;
    } pix_info_t;

endpackage

>>> rtl/bfdm_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read data.
// A read and a write to the same address in one cycle return the old word.
// No dependencies.
module bfdm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

>>> rtl/bfdm_ctrl.sv
// Configuration registers, raster position counters, frame store clearing pass
// and read issue for both memories. Depends on bfdm_pkg.
module bfdm_ctrl
    import bfdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  result_busy,
    output logic                  restart,
    output logic [LIMIT_W-1:0]    limit,
    output logic [MT_W-1:0]       motion_threshold,
    output logic                  frame_we,
    output logic [ADDR_W-1:0]     frame_waddr,
    output logic [PIX_W-1:0]      frame_wdata,
    output logic                  frame_re,
    output logic [ADDR_W-1:0]     frame_raddr,
    output logic                  tile_re,
    output logic [TCOL_W-1:0]     tile_raddr,
    output logic                  s1_valid,
    output pix_info_t             s1_info
);

    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [TT_W-1:0]   tt_reg;
    logic [MT_W-1:0]   mt_reg;
    logic [TSQ_W-1:0]  ts_sq_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [FW_W-1:0]   w;
    logic [FH_W-1:0]   h;
    logic [TS_W-1:0]   ts;

    logic [FW_W-1:0]   col_reg, col_next;
    logic [FH_W-1:0]   line_reg, line_next;
    logic [CIT_W-1:0]  cit_reg, cit_next;
    logic [CIT_W-1:0]  lit_reg, lit_next;
    logic [TCOL_W-1:0] tcol_reg, tcol_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              s1_valid_reg;
    pix_info_t         s1_info_reg;

    logic              accept;
    logic              last_col, last_line, cit_wrap, lit_wrap;
    logic              frame_end_now, tile_done_now;

    // clamp out-of-range settings
    always_comb
    begin
        if (fw_reg == '0)
            w = FW_W'(1);
        else if (fw_reg > FW_W'(MAX_WIDTH))
            w = FW_W'(MAX_WIDTH);
        else
            w = fw_reg;

        if (fh_reg == '0)
            h = FH_W'(1);
        else if (fh_reg > FH_W'(MAX_HEIGHT))
            h = FH_W'(MAX_HEIGHT);
        else
            h = fh_reg;

        if (ts_reg == '0)
            ts = TS_W'(1);
        else if (ts_reg > TS_W'(MAX_TILE))
            ts = TS_W'(MAX_TILE);
        else
            ts = ts_reg;
    end

    always_comb
    begin
        case (cfg_index)
            REG_FRAME_WIDTH,
            REG_FRAME_HEIGHT,
            REG_TILE_SIZE,
            REG_TILE_THRESHOLD,
            REG_MOTION_THRESHOLD: restart = cfg_we;
            default:              restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_RESET;
            fh_reg <= FH_RESET;
            ts_reg <= TS_RESET;
            tt_reg <= TT_RESET;
            mt_reg <= MT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:      fw_reg <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT:     fh_reg <= cfg_data[FH_W-1:0];
                REG_TILE_SIZE:        ts_reg <= cfg_data[TS_W-1:0];
                REG_TILE_THRESHOLD:   tt_reg <= cfg_data[TT_W-1:0];
                REG_MOTION_THRESHOLD: mt_reg <= cfg_data[MT_W-1:0];
                default:              ;
            endcase
        end
    end

    // threshold area, two multiplies in two register steps
    always_ff @(posedge clk)
    begin
        ts_sq_reg <= TSQ_W'(ts * ts);
        limit_reg <= LIMIT_W'(({1'b0, tt_reg} + 8'd1) * ts_sq_reg);
    end

    assign last_col      = ({1'b0, col_reg} + 10'd1) == {1'b0, w};
    assign last_line     = ({1'b0, line_reg} + 9'd1) == {1'b0, h};
    assign cit_wrap      = ({1'b0, cit_reg} + 6'd1) == ts;
    assign lit_wrap      = ({1'b0, lit_reg} + 6'd1) == ts;
    assign frame_end_now = last_col && last_line;
    assign tile_done_now = (cit_wrap || last_col) && (lit_wrap || last_line);

    // hold a frame-end word until no other result is pending
    assign s_tready = !clearing_reg &&
                      !(frame_end_now && ((s1_valid_reg && s1_info_reg.frame_end) ||
                                          result_busy));
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        cit_next  = cit_reg;
        lit_next  = lit_reg;
        tcol_next = tcol_reg;
        addr_next = addr_reg;
        if (restart)
        begin
            col_next  = '0;
            line_next = '0;
            cit_next  = '0;
            lit_next  = '0;
            tcol_next = '0;
            addr_next = '0;
        end
        else if (accept)
        begin
            if (frame_end_now)
            begin
                col_next  = '0;
                line_next = '0;
                cit_next  = '0;
                lit_next  = '0;
                tcol_next = '0;
                addr_next = '0;
            end
            else if (last_col)
            begin
                col_next  = '0;
                cit_next  = '0;
                tcol_next = '0;
                line_next = line_reg + FH_W'(1);
                lit_next  = lit_wrap ? '0 : lit_reg + CIT_W'(1);
                addr_next = addr_reg + ADDR_W'(1);
            end
            else
            begin
                col_next  = col_reg + FW_W'(1);
                addr_next = addr_reg + ADDR_W'(1);
                if (cit_wrap)
                begin
                    cit_next  = '0;
                    tcol_next = tcol_reg + TCOL_W'(1);
                end
                else
                begin
                    cit_next = cit_reg + CIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            line_reg     <= '0;
            cit_reg      <= '0;
            lit_reg      <= '0;
            tcol_reg     <= '0;
            addr_reg     <= '0;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            line_reg     <= line_next;
            cit_reg      <= cit_next;
            lit_reg      <= lit_next;
            tcol_reg     <= tcol_next;
            addr_reg     <= addr_next;
            s1_valid_reg <= accept;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg.pixel      <= s_tdata;
            s1_info_reg.tcol       <= tcol_reg;
            s1_info_reg.first_tile <= (cit_reg == '0) && (lit_reg == '0);
            s1_info_reg.tile_done  <= tile_done_now;
            s1_info_reg.frame_end  <= frame_end_now;
        end
    end

    // frame store: read old word and write new one at the same address
    assign frame_we    = clearing_reg || accept;
    assign frame_waddr = clearing_reg ? clr_addr_reg : addr_reg;
    assign frame_wdata = clearing_reg ? '0 : s_tdata;
    assign frame_re    = accept;
    assign frame_raddr = addr_reg;

    assign tile_re    = accept;
    assign tile_raddr = tcol_reg;

    assign s1_valid         = s1_valid_reg;
    assign s1_info          = s1_info_reg;
    assign limit            = limit_reg;
    assign motion_threshold = mt_reg;

endmodule

>>> rtl/bfdm_accum.sv
// Difference and tile-sum read-modify-write with forwarding, tile judgment,
// changed-tile count and result register. Depends on bfdm_pkg.
module bfdm_accum
    import bfdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic [LIMIT_W-1:0]    limit,
    input  logic [MT_W-1:0]       motion_threshold,
    input  logic                  s1_valid,
    input  pix_info_t             s1_info,
    input  logic [PIX_W-1:0]      prev_pixel,
    input  logic [SUM_W-1:0]      tile_rdata,
    output logic                  tile_we,
    output logic [TCOL_W-1:0]     tile_waddr,
    output logic [SUM_W-1:0]      tile_wdata,
    output logic                  result_busy,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic              wr_valid_reg;
    logic [TCOL_W-1:0] wr_addr_reg;
    logic [SUM_W-1:0]  wr_data_reg;

    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic              s2_done_reg;
    logic              s2_end_reg;

    logic [CNT_W-1:0]  changed_reg, changed_next;
    logic              out_valid_reg;
    logic              out_motion_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic [4:0]        dr, db;
    logic [5:0]        dg;
    logic [DIFF_W-1:0] diff;
    logic [SUM_W-1:0]  base, sum;
    logic              hit;

    always_comb
    begin
        logic [4:0] cr, pr, cb, pb;
        logic [5:0] cg, pg;
        cr = s1_info.pixel[15:11];
        pr = prev_pixel[15:11];
        cg = s1_info.pixel[10:5];
        pg = prev_pixel[10:5];
        cb = s1_info.pixel[4:0];
        pb = prev_pixel[4:0];
        dr = (cr > pr) ? cr - pr : pr - cr;
        dg = (cg > pg) ? cg - pg : pg - cg;
        db = (cb > pb) ? cb - pb : pb - cb;
    end

    assign diff = DIFF_W'(dr) + DIFF_W'(dg) + DIFF_W'(db);

    // forward the last write: the memory read may have raced it
    always_comb
    begin
        if (s1_info.first_tile)
            base = '0;
        else if (wr_valid_reg && (wr_addr_reg == s1_info.tcol))
            base = wr_data_reg;
        else
            base = tile_rdata;
    end

    assign sum        = base + SUM_W'(diff);
    assign tile_we    = s1_valid;
    assign tile_waddr = s1_info.tcol;
    assign tile_wdata = sum;

    assign hit = s2_done_reg && ({1'b0, s2_sum_reg} >= limit);

    always_comb
    begin
        changed_next = changed_reg;
        if (restart)
            changed_next = '0;
        else if (s2_valid_reg)
            changed_next = s2_end_reg ? '0 : changed_reg + CNT_W'(hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            changed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
            changed_reg  <= changed_next;
            if (s1_valid)
            begin
                wr_valid_reg <= 1'b1;
            end
            if (s2_valid_reg && s2_end_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid)
        begin
            wr_addr_reg <= s1_info.tcol;
            wr_data_reg <= sum;
            s2_sum_reg  <= sum;
            s2_done_reg <= s1_info.tile_done;
            s2_end_reg  <= s1_info.frame_end;
        end
        if (s2_valid_reg && s2_end_reg)
        begin
            out_count_reg  <= changed_reg + CNT_W'(hit);
            out_motion_reg <= (changed_reg + CNT_W'(hit)) > motion_threshold;
        end
    end

    assign result_busy = (s2_valid_reg && s2_end_reg) || out_valid_reg;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {{(OUT_DATA_W - CNT_W - 1){1'b0}}, out_count_reg, out_motion_reg};

endmodule

>>> rtl/block_frame_diff_motion.sv
// Block frame-difference motion detector, top level.
// Depends on bfdm_pkg, bfdm_ram, bfdm_ctrl and bfdm_accum.
//
// Takes one RGB565 word per cycle in raster order while s_tready is high, and
// reports, one word after the last pixel of each frame, the number of changed
// tiles and a motion flag. For each pixel the frame store does a read-first
// read and write at the same address at acceptance, and the tile-sum memory is
// read then and written back in the next cycle, with the last write forwarded.
// The frame-end pixel is held while an earlier result is still in the pipeline
// or in the output register, so one-pixel frames wait on the previous result.
// A frame's last pixel passes the s1 and s2 registers, then its result word is
// held in the output register until m_tready. After reset all 76800 words of
// the frame store are cleared, with s_tready low meanwhile. Writes to the five
// registers restart the frame and take effect for a pixel taken in the next cycle.
module block_frame_diff_motion
    import bfdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [15:0] pixel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] motion, [17:1] changed_tiles, zero pad
);

    logic               restart;
    logic [LIMIT_W-1:0] limit;
    logic [MT_W-1:0]    motion_threshold;
    logic               frame_we, frame_re;
    logic [ADDR_W-1:0]  frame_waddr, frame_raddr;
    logic [PIX_W-1:0]   frame_wdata, frame_rdata;
    logic               tile_we, tile_re;
    logic [TCOL_W-1:0]  tile_waddr, tile_raddr;
    logic [SUM_W-1:0]   tile_wdata, tile_rdata;
    logic               s1_valid;
    pix_info_t          s1_info;
    logic               result_busy;

    bfdm_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .result_busy      (result_busy),
        .restart          (restart),
        .limit            (limit),
        .motion_threshold (motion_threshold),
        .frame_we         (frame_we),
        .frame_waddr      (frame_waddr),
        .frame_wdata      (frame_wdata),
        .frame_re         (frame_re),
        .frame_raddr      (frame_raddr),
        .tile_re          (tile_re),
        .tile_raddr       (tile_raddr),
        .s1_valid         (s1_valid),
        .s1_info          (s1_info)
    );

    bfdm_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (PIX_W)
    ) u_frame_mem (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .re    (frame_re),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    bfdm_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (SUM_W)
    ) u_tile_mem (
        .clk   (clk),
        .we    (tile_we),
        .waddr (tile_waddr),
        .wdata (tile_wdata),
        .re    (tile_re),
        .raddr (tile_raddr),
        .rdata (tile_rdata)
    );

    bfdm_accum u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .restart          (restart),
        .limit            (limit),
        .motion_threshold (motion_threshold),
        .s1_valid         (s1_valid),
        .s1_info          (s1_info),
        .prev_pixel       (frame_rdata),
        .tile_rdata       (tile_rdata),
        .tile_we          (tile_we),
        .tile_waddr       (tile_waddr),
        .tile_wdata       (tile_wdata),
        .result_busy      (result_busy),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

>>> rtl/bfdm_checker.sv
// Port-level checker for block_frame_diff_motion, attached by bind.
// Depends on bfdm_pkg.
module bfdm_checker
    import bfdm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // frame store clear keeps input closed through reset
    a_clear_on_reset: assert property (@(posedge clk)
        !rst_n |=> !s_tready)
        else $error("input opened during or right after reset");

    // a rising result valid must follow an accepted pixel
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result without a pixel three cycles earlier");

    // only one result in flight: a taken result is never followed at once
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("back-to-back results");

endmodule

bind block_frame_diff_motion bfdm_checker u_bfdm_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for block_frame_diff_motion (needs bfdm_pkg and the RTL).
// Streams RGB565 frames under changing geometry and thresholds, tracks the frame
// store and tile sums in the bench and checks every frame report word.
module tb_top
    import bfdm_pkg::*;
;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int ITEM_TARGET    = 1850;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_MOTION_THRESHOLD + 1'b1;

    typedef enum int {PIX_FRESH, PIX_STILL, PIX_NUDGE} scene_mode_e;
    typedef enum int {READY_OPEN, READY_COIN, READY_COMB, READY_SPARSE} ready_mode_e;

    typedef struct packed {
        logic             motion;
        logic [CNT_W-1:0] changed_tiles;
    } frame_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;   // [15:0] pixel
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [0] motion, [17:1] changed_tiles, zero pad

    // bench copy of the registers and the block state
    logic [FW_W-1:0]  trk_width;
    logic [FH_W-1:0]  trk_height;
    logic [TS_W-1:0]  trk_tile;
    logic [TT_W-1:0]  trk_tile_thr;
    logic [MT_W-1:0]  trk_motion_thr;
    logic [PIX_W-1:0] scene_store [STORE_DEPTH];
    logic [SUM_W-1:0] tile_acc [MAX_WIDTH];
    logic [CNT_W-1:0] changed_cnt;
    int unsigned      col_pos;
    int unsigned      line_pos;
    int unsigned      col_in_tile;
    int unsigned      line_in_tile;
    int unsigned      tile_col;

    frame_report_t reports_due[$];
    int unsigned   pixels_sent;
    int unsigned   burst_left;
    int unsigned   fail_count;
    int unsigned   quiet_cycles = 0;
    bit            sender_gaps;

    block_frame_diff_motion u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned comp_diff(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void restart_position();
        col_pos      = 0;
        line_pos     = 0;
        col_in_tile  = 0;
        line_in_tile = 0;
        tile_col     = 0;
        changed_cnt  = '0;
    endfunction

    function automatic void reset_tracker();
        trk_width      = FW_RESET;
        trk_height     = FH_RESET;
        trk_tile       = TS_RESET;
        trk_tile_thr   = TT_RESET;
        trk_motion_thr = MT_RESET;
        foreach (scene_store[i])
            scene_store[i] = '0;
        foreach (tile_acc[i])
            tile_acc[i] = '0;
        reports_due.delete();
        restart_position();
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_FRAME_WIDTH:      trk_width      = value[FW_W-1:0];
            REG_FRAME_HEIGHT:     trk_height     = value[FH_W-1:0];
            REG_TILE_SIZE:        trk_tile       = value[TS_W-1:0];
            REG_TILE_THRESHOLD:   trk_tile_thr   = value[TT_W-1:0];
            REG_MOTION_THRESHOLD: trk_motion_thr = value[MT_W-1:0];
            default:              return;
        endcase
        restart_position();
    endfunction

    // store address of the next pixel; a stale position restarts at the origin
    function automatic int unsigned cursor_addr();
        int unsigned w;
        int unsigned h;
        int unsigned ts;
        int unsigned addr;
        w  = clamp_reg(trk_width, MAX_WIDTH);
        h  = clamp_reg(trk_height, MAX_HEIGHT);
        ts = clamp_reg(trk_tile, MAX_TILE);
        if (col_pos >= w || line_pos >= h || col_in_tile >= ts || line_in_tile >= ts)
            return 0;
        addr = line_pos * w + col_pos;
        return (addr >= STORE_DEPTH) ? 0 : addr;
    endfunction

    function automatic void track_pixel(logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      ts;
        int unsigned      addr;
        int unsigned      diff;
        int unsigned      tcol;
        int unsigned      thr_area;
        logic [PIX_W-1:0] old;
        bit               row_end;
        bit               last_line;
        bit               tile_closed;
        frame_report_t    rep;
        w  = clamp_reg(trk_width, MAX_WIDTH);
        h  = clamp_reg(trk_height, MAX_HEIGHT);
        ts = clamp_reg(trk_tile, MAX_TILE);
        if (col_pos >= w || line_pos >= h || col_in_tile >= ts || line_in_tile >= ts)
            restart_position();
        addr = cursor_addr();
        old = scene_store[addr];
        scene_store[addr] = px;
        diff = comp_diff(px[15:11], old[15:11]) + comp_diff(px[10:5], old[10:5])
             + comp_diff(px[4:0], old[4:0]);

        tcol = (tile_col >= MAX_WIDTH) ? 0 : tile_col;
        if (col_in_tile == 0 && line_in_tile == 0)
            tile_acc[tcol] = SUM_W'(diff);
        else
            tile_acc[tcol] = SUM_W'(tile_acc[tcol] + diff);

        // partial edge tiles still face the full-area threshold
        row_end     = (col_pos + 1 == w);
        last_line   = (line_pos + 1 == h);
        tile_closed = (col_in_tile + 1 == ts || row_end) &&
                      (line_in_tile + 1 == ts || last_line);
        thr_area    = (int'(trk_tile_thr) + 1) * ts * ts;
        if (tile_closed && tile_acc[tcol] >= thr_area)
            changed_cnt = changed_cnt + 1'b1;

        if (row_end && last_line)
        begin
            rep.motion        = (changed_cnt > trk_motion_thr);
            rep.changed_tiles = changed_cnt;
            reports_due.push_back(rep);
            restart_position();
            return;
        end

        if (row_end)
        begin
            col_pos      = 0;
            col_in_tile  = 0;
            tile_col     = 0;
            line_pos++;
            line_in_tile = (line_in_tile + 1 == ts) ? 0 : line_in_tile + 1;
        end
        else
        begin
            col_pos++;
            if (col_in_tile + 1 == ts)
            begin
                col_in_tile = 0;
                tile_col++;
            end
            else
                col_in_tile++;
        end
    endfunction

    task automatic stream_pause(int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] px);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps)
                stream_pause($urandom_range(1, 6));
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_scene(scene_mode_e mode, int unsigned count);
        logic [PIX_W-1:0] px;
        repeat (count)
        begin
            case (mode)
                PIX_STILL: px = scene_store[cursor_addr()];
                PIX_NUDGE: px = scene_store[cursor_addr()] ^ (16'h1 << $urandom_range(0, 15));
                default:   px = PIX_W'($urandom_range(0, 16'hFFFF));
            endcase
            send_pixel(px);
        end
    endtask

    // hold the stream until every report is out and the pipeline has emptied
    task automatic drain_reports();
        stream_pause(1);
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, CFG_DATA_W'(value));
    endtask

    task automatic test_component_extremes();
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 2);
        write_reg(REG_TILE_SIZE, 1);
        write_reg(REG_TILE_THRESHOLD, 0);
        write_reg(REG_MOTION_THRESHOLD, 0);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h001F);
        send_pixel(16'hF81F);
        send_scene(PIX_STILL, 4);
        drain_reports();
    endtask

    // zero geometry registers clamp to a one-pixel frame
    task automatic test_register_floor();
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        write_reg(REG_TILE_SIZE, 0);
        send_pixel(16'h5A5A);
        send_pixel(16'hA5A5);
        drain_reports();
    endtask

    task automatic test_restart_mid_frame();
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 2);
        write_reg(REG_TILE_SIZE, 2);
        write_reg(REG_TILE_THRESHOLD, 5);
        write_reg(REG_MOTION_THRESHOLD, 1);
        send_scene(PIX_FRESH, 2);
        drain_reports();
        write_reg(REG_TILE_THRESHOLD, 3);
        send_scene(PIX_FRESH, 6);
        drain_reports();
    endtask

    // writes to unused indexes must neither land nor restart the frame
    task automatic test_unused_indexes();
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 2);
        send_scene(PIX_FRESH, 2);
        drain_reports();
        for (int i = int'(REG_SPARE_FIRST); i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), '1);
        send_scene(PIX_FRESH, 2);
        drain_reports();
    endtask

    task automatic test_full_span();
        write_reg(REG_FRAME_WIDTH, 511);
        write_reg(REG_FRAME_HEIGHT, 1);
        write_reg(REG_TILE_SIZE, 63);
        write_reg(REG_TILE_THRESHOLD, 127);
        write_reg(REG_MOTION_THRESHOLD, 76800);
        send_scene(PIX_FRESH, MAX_WIDTH);
        drain_reports();
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 255);
        write_reg(REG_TILE_SIZE, MAX_TILE);
        write_reg(REG_TILE_THRESHOLD, 0);
        write_reg(REG_MOTION_THRESHOLD, 0);
        send_scene(PIX_FRESH, MAX_HEIGHT);
        drain_reports();
    endtask

    task automatic test_random_phases();
        int unsigned phase;
        int unsigned w;
        int unsigned h;
        int unsigned area;
        scene_mode_e mode;
        phase = 0;
        while (pixels_sent < ITEM_TARGET)
        begin
            drain_reports();
            sender_gaps = ($urandom_range(0, 3) != 0);
            if (phase == 0 || $urandom_range(0, 1))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    w = $urandom_range(13, 48);
                    h = $urandom_range(1, 3);
                end
                else
                begin
                    w = $urandom_range(0, 12);
                    h = $urandom_range(0, 8);
                end
                write_reg(REG_FRAME_WIDTH, w);
                write_reg(REG_FRAME_HEIGHT, h);
            end
            if (phase == 0 || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_TILE_SIZE, $urandom_range(MAX_TILE + 1, 63));
                    1, 2:    write_reg(REG_TILE_SIZE, $urandom_range(5, MAX_TILE));
                    default: write_reg(REG_TILE_SIZE, $urandom_range(0, 4));
                endcase
            end
            if ($urandom_range(0, 1))
                write_reg(REG_TILE_THRESHOLD,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 40));
            if ($urandom_range(0, 1))
                write_reg(REG_MOTION_THRESHOLD,
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17'h1FFFF)
                                                      : $urandom_range(0, 6));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, 2)),
                          $urandom_range(0, 17'h1FFFF));

            area = clamp_reg(trk_width, MAX_WIDTH) * clamp_reg(trk_height, MAX_HEIGHT);
            repeat ($urandom_range(1, 4))
            begin
                mode = $urandom_range(0, 1) ? PIX_FRESH
                                            : scene_mode_e'($urandom_range(PIX_STILL, PIX_NUDGE));
                send_scene(mode, area);
            end
            // leave a frame unfinished now and then; the next write to a defined register drops it
            if (area > 1 && $urandom_range(0, 7) == 0)
                send_scene(PIX_FRESH, $urandom_range(1, area - 1));
            phase++;
        end
    endtask

    // receiver: switch between stall patterns at random intervals
    initial
    begin
        ready_mode_e rmode;
        int unsigned span;
        m_tready = 1'b0;
        forever
        begin
            rmode = ready_mode_e'($urandom_range(READY_OPEN, READY_SPARSE));
            span  = $urandom_range(16, 160);
            for (int tick = 0; tick < span; tick++)
            begin
                @(negedge clk);
                case (rmode)
                    READY_OPEN:  m_tready <= 1'b1;
                    READY_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    READY_COMB:  m_tready <= (tick % 5) != 0;
                    default:     m_tready <= ($urandom_range(0, 11) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        frame_report_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("frame report with none pending: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                due = reports_due.pop_front();
                if (m_tdata[0] !== due.motion)
                begin
                    $error("motion: expected %0d, got %0d", due.motion, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[CNT_W:1] !== due.changed_tiles)
                begin
                    $error("changed_tiles: expected %0d, got %0d",
                           due.changed_tiles, m_tdata[CNT_W:1]);
                    fail_count++;
                end
                if (m_tdata[OUT_DATA_W-1:CNT_W+1] !== '0)
                begin
                    $error("pad: expected 0, got %h", m_tdata[OUT_DATA_W-1:CNT_W+1]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: the post-reset store clear is the longest legal silence
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        pixels_sent = 0;
        burst_left  = 0;
        fail_count  = 0;
        sender_gaps = 1'b1;
        reset_tracker();
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_component_extremes();
        test_register_floor();
        test_restart_mid_frame();
        test_unused_indexes();
        test_full_span();
        test_random_phases();
        drain_reports();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
